>>> design/wst_pkg.sv
// Shared widths, register codes, configuration and job types for the wave stencil step.
`timescale 1ns / 1ps
`default_nettype none
package wst_pkg;

	localparam int unsigned DATA_W         = 32;
	localparam int unsigned WIDE_W         = 48;
	localparam int unsigned COEF_W         = 31;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned MAX_POINTS_DEF = 1024;
	localparam int unsigned IDX_W_DEF      = $clog2(MAX_POINTS_DEF + 1);
	localparam int unsigned QUEUE_DEPTH    = 2;

	localparam logic [COEF_W-1:0] INV_DX2_RESET = COEF_W'(65536);
	localparam logic [COEF_W-1:0] INV_2DX_RESET = COEF_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_STEP_MODE = 3'd0,
		REG_STEP_TIME       = 3'd1,
		REG_STEP_TIME_SQ    = 3'd2,
		REG_INV_DX2         = 3'd3,
		REG_INV_2DX         = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              first_step_mode;
		logic [COEF_W-1:0] step_time;
		logic [COEF_W-1:0] step_time_squared;
		logic [COEF_W-1:0] inv_space_step_squared;
		logic [COEF_W-1:0] inv_twice_space_step;
	} cfg_t;

	// One queued job: an interior update, a boundary word, or both (interior first).
	typedef struct packed {
		logic                     has_int;
		logic                     has_bnd;
		logic                     bnd_last;
		logic signed [DATA_W-1:0] right;
		logic signed [DATA_W-1:0] centre;
		logic signed [DATA_W-1:0] left;
		logic signed [DATA_W-1:0] back;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] p;
		logic signed [DATA_W-1:0] q;
		logic signed [DATA_W-1:0] f;
		logic signed [DATA_W-1:0] bnd;
	} job_t;

endpackage
`default_nettype wire

>>> design/wst_if.sv
// Stream interfaces for grid point words in and next-layer words out.
`timescale 1ns / 1ps
`default_nettype none
interface wst_in_if;
	import wst_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] layer_value;
	logic signed [DATA_W-1:0] back_value;
	logic signed [DATA_W-1:0] velocity;
	logic signed [DATA_W-1:0] coef_p;
	logic signed [DATA_W-1:0] coef_q;
	logic signed [DATA_W-1:0] coef_f;
	logic signed [DATA_W-1:0] boundary_value;
	logic                     is_first;
	logic                     is_last;

	modport source (
		output valid, layer_value, back_value, velocity, coef_p, coef_q, coef_f,
		       boundary_value, is_first, is_last,
		input  ready
	);
	modport sink (
		input  valid, layer_value, back_value, velocity, coef_p, coef_q, coef_f,
		       boundary_value, is_first, is_last,
		output ready
	);
endinterface

interface wst_out_if #(
	parameter int unsigned IDX_W = wst_pkg::IDX_W_DEF
);
	import wst_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] new_value;
	logic [IDX_W-1:0]         point_index;
	logic                     saturated;
	logic                     last_of_layer;

	modport source (
		output valid, new_value, point_index, saturated, last_of_layer,
		input  ready
	);
	modport sink (
		input  valid, new_value, point_index, saturated, last_of_layer,
		output ready
	);
endinterface
`default_nettype wire

>>> design/wst_mulq.sv
// Multi-cycle Q16.16 multiplier: 48 x 32 bits in two 25 x 32 passes, floor shift, 48-bit clip.
`timescale 1ns / 1ps
`default_nettype none
module wst_mulq (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	input  wire logic signed [wst_pkg::WIDE_W-1:0] a,
	input  wire logic signed [wst_pkg::DATA_W-1:0] b,
	output logic                                   busy,
	output logic                                   done,
	output logic signed [wst_pkg::WIDE_W-1:0]      y,
	output logic                                   clip
);
	import wst_pkg::*;

	localparam int unsigned HALF_W = WIDE_W / 2;
	localparam int unsigned PART_W = HALF_W + 1;
	localparam int unsigned PROD_W = PART_W + DATA_W;
	localparam int unsigned FULL_W = PROD_W + HALF_W;
	localparam int unsigned SHFT_W = FULL_W - 16;

	typedef enum logic [1:0] {PH_LO, PH_HI, PH_SUM} phase_t;

	phase_t                   ph_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [WIDE_W-1:0] a_q;
	logic signed [DATA_W-1:0] b_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] lo_q;
	logic signed [WIDE_W-1:0] y_q;
	logic                     clip_q;

	logic signed [PART_W-1:0] part;
	logic signed [PROD_W-1:0] prod;
	logic signed [FULL_W-1:0] full;
	logic [SHFT_W-1:0]        shifted;
	logic                     fits;

	always_comb begin
		if (ph_q == PH_LO) begin
			part = $signed({1'b0, a_q[HALF_W-1:0]});
		end else begin
			part = $signed({a_q[WIDE_W-1], a_q[WIDE_W-1:HALF_W]});
		end
		prod    = part * b_q;
		// high partial weighs 2^24; the sum is exact, then floor by 2^16
		full    = $signed({prod_q, {HALF_W{1'b0}}}) + $signed({{HALF_W{lo_q[PROD_W-1]}}, lo_q});
		shifted = full[FULL_W-1:16];
		fits    = (&shifted[SHFT_W-1:WIDE_W-1]) | ~(|shifted[SHFT_W-1:WIDE_W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_LO;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				case (ph_q)
					PH_LO: begin
						prod_q <= prod;
						ph_q   <= PH_HI;
					end
					PH_HI: begin
						lo_q   <= prod_q;
						prod_q <= prod;
						ph_q   <= PH_SUM;
					end
					PH_SUM: begin
						if (fits) begin
							y_q <= shifted[WIDE_W-1:0];
						end else begin
							y_q <= shifted[SHFT_W-1] ? {1'b1, {(WIDE_W-1){1'b0}}}
							                          : {1'b0, {(WIDE_W-1){1'b1}}};
						end
						clip_q <= !fits;
						done_q <= 1'b1;
						busy_q <= 1'b0;
						ph_q   <= PH_LO;
					end
					default: begin
						ph_q <= PH_LO;
					end
				endcase
			end else if (start) begin
				a_q    <= a;
				b_q    <= b;
				ph_q   <= PH_LO;
				busy_q <= 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign y    = y_q;
	assign clip = clip_q;

endmodule
`default_nettype wire

>>> design/wst_front.sv
// Front end: accept grid point words, keep the three-point window, classify into jobs.
`timescale 1ns / 1ps
`default_nettype none
module wst_front #(
	parameter int unsigned MAX_POINTS = wst_pkg::MAX_POINTS_DEF,
	parameter int unsigned IDX_W      = $clog2(MAX_POINTS + 1)
) (
	input  wire               clk,
	input  wire               arst_n,
	wst_in_if.sink            items,
	output logic              push_valid,
	input  wire               push_ready,
	output wst_pkg::job_t     push_job,
	output logic [IDX_W-1:0]  push_idx
);
	import wst_pkg::*;

	localparam logic [IDX_W-1:0] LIMIT = IDX_W'(MAX_POINTS);

	logic signed [DATA_W-1:0] left_q;
	logic signed [DATA_W-1:0] centre_q;
	logic signed [DATA_W-1:0] back_q;
	logic signed [DATA_W-1:0] vel_q;
	logic signed [DATA_W-1:0] p_q;
	logic signed [DATA_W-1:0] q_q;
	logic signed [DATA_W-1:0] f_q;
	logic [IDX_W-1:0]         count_q;

	logic [IDX_W-1:0] idx;
	logic             last;
	logic             accept;

	always_comb begin
		idx  = items.is_first ? '0 : count_q;
		last = items.is_last || (idx >= LIMIT);

		push_job.has_int  = idx >= IDX_W'(2);
		push_job.has_bnd  = (idx == '0) || last;
		push_job.bnd_last = last;
		push_job.right    = items.layer_value;
		push_job.centre   = centre_q;
		push_job.left     = left_q;
		push_job.back     = back_q;
		push_job.vel      = vel_q;
		push_job.p        = p_q;
		push_job.q        = q_q;
		push_job.f        = f_q;
		push_job.bnd      = items.boundary_value;
		push_idx          = idx;

		// the second point of a layer yields no word unless it ends the layer
		push_valid  = items.valid && (push_job.has_int || push_job.has_bnd);
		items.ready = push_ready;
		accept      = items.valid && push_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			centre_q <= '0;
			back_q   <= '0;
			vel_q    <= '0;
			p_q      <= '0;
			q_q      <= '0;
			f_q      <= '0;
			count_q  <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
			end else begin
				left_q   <= centre_q;
				centre_q <= items.layer_value;
				back_q   <= items.back_value;
				vel_q    <= items.velocity;
				p_q      <= items.coef_p;
				q_q      <= items.coef_q;
				f_q      <= items.coef_f;
				count_q  <= idx + IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/wst_queue.sv
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module wst_queue #(
	parameter int unsigned IDX_W = wst_pkg::IDX_W_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push_valid,
	output logic              push_ready,
	input  wst_pkg::job_t     push_job,
	input  wire [IDX_W-1:0]   push_idx,
	output logic              pop_valid,
	input  wire               pop_ready,
	output wst_pkg::job_t     pop_job,
	output logic [IDX_W-1:0]  pop_idx
);
	import wst_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	job_t             job_mem [QUEUE_DEPTH];
	logic [IDX_W-1:0] idx_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != FULL_CNT;
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = job_mem[rd_ptr_q];
	assign pop_idx    = idx_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			job_mem[wr_ptr_q] <= push_job;
			idx_mem[wr_ptr_q] <= push_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/wst_back.sv
// Back end: sequence the stencil arithmetic on a shared multiplier and drive result words.
`timescale 1ns / 1ps
`default_nettype none
module wst_back #(
	parameter int unsigned IDX_W = wst_pkg::IDX_W_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wst_pkg::cfg_t     cfg,
	input  wire               pop_valid,
	output logic              pop_ready,
	input  wst_pkg::job_t     pop_job,
	input  wire [IDX_W-1:0]   pop_idx,
	wst_out_if.source         results
);
	import wst_pkg::*;

	localparam int unsigned SUM_W = WIDE_W + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LAP, ST_DER1, ST_DER2, ST_REACT, ST_FORCE,
		ST_TIME, ST_VEL, ST_FINAL, ST_EMIT_INT, ST_EMIT_BND
	} state_t;

	typedef struct packed {
		logic                     clip;
		logic signed [WIDE_W-1:0] v;
	} wide_t;

	function automatic logic [SUM_W-1:0] sxn(input logic [DATA_W-1:0] x);
		return {{(SUM_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

	function automatic logic [SUM_W-1:0] sxw(input logic [WIDE_W-1:0] x);
		return {{(SUM_W-WIDE_W){x[WIDE_W-1]}}, x};
	endfunction

	function automatic wide_t sat48(input logic [SUM_W-1:0] x);
		wide_t r;
		r.clip = !((&x[SUM_W-1:WIDE_W-1]) | ~(|x[SUM_W-1:WIDE_W-1]));
		if (!r.clip) begin
			r.v = x[WIDE_W-1:0];
		end else begin
			r.v = x[SUM_W-1] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
		end
		return r;
	endfunction

	// second difference r - 2c + l, never clips at 48 bits
	function automatic logic [WIDE_W-1:0] lap(input job_t j);
		logic [SUM_W-1:0] t;
		t = sxn(j.right) - sxn(j.centre) - sxn(j.centre) + sxn(j.left);
		return t[WIDE_W-1:0];
	endfunction

	state_t                   state_q;
	job_t                     job_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [WIDE_W-1:0] s_q;
	logic signed [WIDE_W-1:0] t_q;
	logic signed [WIDE_W-1:0] vt_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     clip_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [IDX_W-1:0]         out_index_q;
	logic                     out_sat_q;
	logic                     out_last_q;

	logic                     mstart;
	logic signed [WIDE_W-1:0] ma;
	logic signed [DATA_W-1:0] mb;
	logic                     mbusy;
	logic                     mdone;
	logic signed [WIDE_W-1:0] my;
	logic                     mclip;

	wide_t                    sum_m;
	wide_t                    sum_f;
	logic [SUM_W-1:0]         fin;
	logic                     fin_fits;
	logic signed [DATA_W-1:0] fin_val;
	logic                     slot_free;
	logic [SUM_W-1:0]         d1;
	logic signed [WIDE_W-1:0] centre_w;
	logic signed [WIDE_W-1:0] vel_w;
	logic                     emit;

	wst_mulq u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.a      (ma),
		.b      (mb),
		.busy   (mbusy),
		.done   (mdone),
		.y      (my),
		.clip   (mclip)
	);

	always_comb begin
		sum_m    = sat48(sxw(s_q) + sxw(my));
		sum_f    = sat48(sxw(s_q) + sxn(job_q.f));
		d1       = sxn(job_q.right) - sxn(job_q.left);
		centre_w = {{(WIDE_W-DATA_W){job_q.centre[DATA_W-1]}}, job_q.centre};
		vel_w    = {{(WIDE_W-DATA_W){job_q.vel[DATA_W-1]}}, job_q.vel};
		if (cfg.first_step_mode) begin
			fin = sxn(job_q.centre) + sxw(vt_q) + sxw(t_q >>> 1);
		end else begin
			fin = sxn(job_q.centre) + sxn(job_q.centre) - sxn(job_q.back) + sxw(t_q);
		end
		fin_fits = (&fin[SUM_W-1:DATA_W-1]) | ~(|fin[SUM_W-1:DATA_W-1]);
		if (fin_fits) begin
			fin_val = fin[DATA_W-1:0];
		end else begin
			fin_val = fin[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
		slot_free = !out_valid_q || results.ready;
		emit      = slot_free && (state_q == ST_EMIT_INT || state_q == ST_EMIT_BND);

		mstart    = 1'b0;
		ma        = '0;
		mb        = '0;
		pop_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid && pop_job.has_int) begin
					mstart = 1'b1;
					ma     = lap(pop_job);
					mb     = {1'b0, cfg.inv_space_step_squared};
				end
			end
			ST_LAP: begin
				if (mdone) begin
					mstart = 1'b1;
					ma     = d1[WIDE_W-1:0];
					mb     = job_q.p;
				end
			end
			ST_DER1: begin
				if (mdone) begin
					mstart = 1'b1;
					ma     = my;
					mb     = {1'b0, cfg.inv_twice_space_step};
				end
			end
			ST_DER2: begin
				if (mdone) begin
					mstart = 1'b1;
					ma     = centre_w;
					mb     = job_q.q;
				end
			end
			ST_FORCE: begin
				mstart = 1'b1;
				ma     = sum_f.v;
				mb     = {1'b0, cfg.step_time_squared};
			end
			ST_TIME: begin
				if (mdone && cfg.first_step_mode) begin
					mstart = 1'b1;
					ma     = vel_w;
					mb     = {1'b0, cfg.step_time};
				end
			end
			default: begin
				mstart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && results.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						job_q   <= pop_job;
						idx_q   <= pop_idx;
						clip_q  <= 1'b0;
						state_q <= pop_job.has_int ? ST_LAP : ST_EMIT_BND;
					end
				end
				ST_LAP: begin
					if (mdone) begin
						s_q     <= my;
						clip_q  <= clip_q | mclip;
						state_q <= ST_DER1;
					end
				end
				ST_DER1: begin
					if (mdone) begin
						clip_q  <= clip_q | mclip;
						state_q <= ST_DER2;
					end
				end
				ST_DER2: begin
					if (mdone) begin
						s_q     <= sum_m.v;
						clip_q  <= clip_q | mclip | sum_m.clip;
						state_q <= ST_REACT;
					end
				end
				ST_REACT: begin
					if (mdone) begin
						s_q     <= sum_m.v;
						clip_q  <= clip_q | mclip | sum_m.clip;
						state_q <= ST_FORCE;
					end
				end
				ST_FORCE: begin
					clip_q  <= clip_q | sum_f.clip;
					state_q <= ST_TIME;
				end
				ST_TIME: begin
					if (mdone) begin
						t_q     <= my;
						clip_q  <= clip_q | mclip;
						state_q <= cfg.first_step_mode ? ST_VEL : ST_FINAL;
					end
				end
				ST_VEL: begin
					if (mdone) begin
						vt_q    <= my;
						clip_q  <= clip_q | mclip;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					res_q   <= fin_val;
					clip_q  <= clip_q | !fin_fits;
					state_q <= ST_EMIT_INT;
				end
				ST_EMIT_INT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						out_index_q <= idx_q - IDX_W'(1);
						out_sat_q   <= clip_q;
						out_last_q  <= 1'b0;
						state_q     <= job_q.has_bnd ? ST_EMIT_BND : ST_IDLE;
					end
				end
				ST_EMIT_BND: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= job_q.bnd;
						out_index_q <= idx_q;
						out_sat_q   <= 1'b0;
						out_last_q  <= job_q.bnd_last;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid         = out_valid_q;
	assign results.new_value     = out_value_q;
	assign results.point_index   = out_index_q;
	assign results.saturated     = out_sat_q;
	assign results.last_of_layer = out_last_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> (state_q == ST_LAP || state_q == ST_DER1 || state_q == ST_DER2 ||
		           state_q == ST_REACT || state_q == ST_TIME || state_q == ST_VEL))
		else $error("multiplier finished outside a wait state");

	a_pop_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |-> !mbusy)
		else $error("job taken while multiplier still busy");

	a_layer_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> !out_sat_q)
		else $error("boundary word flagged as clipped");

	a_int_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_INT) |-> (idx_q >= IDX_W'(2)))
		else $error("interior word for a point below index one");

endmodule
`default_nettype wire

>>> design/wave_equation_stencil_step.sv
// Top level of the explicit finite-difference wave equation step, one grid point per word.
//
//   channel   direction  handshake          payload
//   items     in         valid / ready      layer, back, velocity, p, q, f, boundary, flags
//   results   out        valid / ready      new_value, point_index, saturated, last_of_layer
//   cfg       in         cfg_we only        cfg_index, cfg_data (31 bits)
//
// Each interior point uses the back end's shared 25 x 32 multiplier, which needs two
// passes and a summing step per Q16.16 product, five products per point (six in
// first-step mode). A right boundary word follows its interior word; a boundary-only
// word skips the arithmetic. The front end keeps accepting words while the two-entry
// job queue has room, so the input side runs ahead of the arithmetic by up to two jobs.
// Reset clears the window, the point counter, the queue and the sequencer at once; the
// output register holds a word until results.ready takes it; only the next emit waits.
`timescale 1ns / 1ps
`default_nettype none
module wave_equation_stencil_step #(
	parameter int unsigned MAX_POINTS = wst_pkg::MAX_POINTS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	wst_in_if.sink                             items,
	wst_out_if.source                          results,
	input  wire                                cfg_we,
	input  wire [wst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [wst_pkg::COEF_W-1:0]          cfg_data
);
	import wst_pkg::*;

	// index wide enough for the point that forces a layer end
	localparam int unsigned IDX_W = $clog2(MAX_POINTS + 1);

	cfg_t cfg_q;

	// front to queue
	logic             push_valid;
	logic             push_ready;
	job_t             push_job;
	logic [IDX_W-1:0] push_idx;

	// queue to back
	logic             pop_valid;
	logic             pop_ready;
	job_t             pop_job;
	logic [IDX_W-1:0] pop_idx;

	// Register file: the user must make writes only while the block is drained; the block
	// itself does not enforce this. The back end reads these directly with no shadow copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_step_mode        <= 1'b0;
			cfg_q.step_time              <= '0;
			cfg_q.step_time_squared      <= '0;
			cfg_q.inv_space_step_squared <= INV_DX2_RESET;
			cfg_q.inv_twice_space_step   <= INV_2DX_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FIRST_STEP_MODE: cfg_q.first_step_mode        <= cfg_data[0];
				REG_STEP_TIME:       cfg_q.step_time              <= cfg_data;
				REG_STEP_TIME_SQ:    cfg_q.step_time_squared      <= cfg_data;
				REG_INV_DX2:         cfg_q.inv_space_step_squared <= cfg_data;
				REG_INV_2DX:         cfg_q.inv_twice_space_step   <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// Front: track the window and point counter, turn each word into at most one job.
	wst_front #(
		.MAX_POINTS (MAX_POINTS),
		.IDX_W      (IDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.push_idx   (push_idx)
	);

	// Queue: decouple word intake from the long arithmetic sequence.
	wst_queue #(
		.IDX_W (IDX_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.push_idx   (push_idx),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job),
		.pop_idx    (pop_idx)
	);

	// Back: evaluate the stencil, saturate, emit interior then boundary words in order.
	wst_back #(
		.IDX_W (IDX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.pop_idx   (pop_idx),
		.results   (results)
	);

endmodule
`default_nettype wire

>>> tb/wave_equation_stencil_step_tb.sv
// Self-checking bench for the wave equation stencil step against an inline predictor.
`timescale 1ns / 1ps
module wave_equation_stencil_step_tb;
	import wst_pkg::*;

	localparam int unsigned GRID_MAX = MAX_POINTS_DEF;
	localparam int unsigned IDLE_PCT = 17;   // chance in a hundred that a side idles this cycle
	localparam int unsigned SETTLE   = 120;  // covers a queued interior job plus its boundary word
	localparam int unsigned WATCHDOG = 4000; // cycles without any handshake before giving up

	// Wide enough for any 48-bit value times a 32-bit value with no wrap.
	typedef logic signed [95:0] acc_t;

	localparam acc_t WIDE_HI = (acc_t'(1) << (WIDE_W - 1)) - 1;
	localparam acc_t WIDE_LO = -(acc_t'(1) << (WIDE_W - 1));
	localparam acc_t Q_HI    = (acc_t'(1) << (DATA_W - 1)) - 1;
	localparam acc_t Q_LO    = -(acc_t'(1) << (DATA_W - 1));

	localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
	localparam logic [COEF_W-1:0]        COEF_MAX = '1;

	typedef struct packed {
		logic signed [DATA_W-1:0] layer_value;
		logic signed [DATA_W-1:0] back_value;
		logic signed [DATA_W-1:0] velocity;
		logic signed [DATA_W-1:0] coef_p;
		logic signed [DATA_W-1:0] coef_q;
		logic signed [DATA_W-1:0] coef_f;
		logic signed [DATA_W-1:0] boundary_value;
		logic                     is_first;
		logic                     is_last;
	} grid_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] new_value;
		logic [IDX_W_DEF-1:0]     point_index;
		logic                     saturated;
		logic                     last_of_layer;
	} layer_word_t;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	cfg_reg_t             cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	wst_in_if  point_bus ();
	wst_out_if result_bus ();

	wave_equation_stencil_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (point_bus),
		.results   (result_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor copy of the register file.
	bit   mode_first;
	acc_t ht, ht2, inv_dx2, inv_2dx;

	// Predictor copy of the three-point window and the centre's side data.
	acc_t        win_left, win_centre, held_back, held_vel, held_p, held_q, held_f;
	int unsigned grid_pos;
	bit          clip_hit;

	grid_word_t  pending_points[$];  // words waiting for the driver
	layer_word_t due_results[$];     // next-layer words the block still owes
	grid_word_t  on_bus;             // word the driver currently offers

	int unsigned points_pushed, points_taken, results_taken, clipped_seen;
	int unsigned layers_closed, mismatches, settings_used, quiet;
	bit          steady;             // suppress random idling on both sides

	// Clip to the signed 48-bit working range and note any clipping.
	function automatic acc_t clamp48(acc_t x);
		if (x > WIDE_HI) begin
			clip_hit = 1'b1;
			return WIDE_HI;
		end
		if (x < WIDE_LO) begin
			clip_hit = 1'b1;
			return WIDE_LO;
		end
		return x;
	endfunction

	// Q16.16 product, floored toward minus infinity, then clipped.
	function automatic acc_t qmul(acc_t a, acc_t b);
		return clamp48((a * b) >>> 16);
	endfunction

	// Next-layer value of the window centre, with the incoming point as its right neighbor.
	function automatic logic signed [DATA_W-1:0] centre_update(acc_t right, output bit clipped);
		acc_t s, t, res;
		clip_hit = 1'b0;
		// S = u_xx + p*u_x + q*u + f, summed in the wide range
		s = qmul(clamp48(right - 2 * win_centre + win_left), inv_dx2);
		t = qmul(qmul(clamp48(right - win_left), held_p), inv_2dx);
		s = clamp48(s + t);
		s = clamp48(s + qmul(win_centre, held_q));
		s = clamp48(s + held_f);
		t = qmul(s, ht2);
		if (mode_first)
			res = clamp48(win_centre + qmul(held_vel, ht) + (t >>> 1));
		else
			res = clamp48(2 * win_centre - held_back + t);
		if (res > Q_HI) begin
			clip_hit = 1'b1;
			res = Q_HI;
		end
		if (res < Q_LO) begin
			clip_hit = 1'b1;
			res = Q_LO;
		end
		clipped = clip_hit;
		return res[DATA_W-1:0];
	endfunction

	// Queue the words one accepted grid word causes and advance the window.
	task automatic predict_grid_word(grid_word_t w);
		int unsigned              pos;
		bit                       ends, clipped;
		logic signed [DATA_W-1:0] val;
		pos  = w.is_first ? 0 : grid_pos;
		ends = w.is_last || pos >= GRID_MAX;
		// point zero: left boundary word, which also closes a one-point layer
		if (pos == 0) begin
			due_results.push_back('{w.boundary_value, '0, 1'b0, w.is_last});
		end else if (pos >= 2) begin
			val = centre_update(acc_t'(w.layer_value), clipped);
			due_results.push_back('{val, IDX_W_DEF'(pos - 1), clipped, 1'b0});
		end
		// right boundary word trails the last interior word
		if (pos != 0 && ends)
			due_results.push_back('{w.boundary_value, IDX_W_DEF'(pos), 1'b0, 1'b1});
		if (ends) begin
			grid_pos = 0;
		end else begin
			win_left   = win_centre;
			win_centre = acc_t'(w.layer_value);
			held_back  = acc_t'(w.back_value);
			held_vel   = acc_t'(w.velocity);
			held_p     = acc_t'(w.coef_p);
			held_q     = acc_t'(w.coef_q);
			held_f     = acc_t'(w.coef_f);
			grid_pos   = pos + 1;
		end
	endtask

	function automatic void check_field(string what, longint want, longint got);
		if (got != want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Driver: predict on acceptance, then offer the next word or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (point_bus.valid && point_bus.ready) begin
				predict_grid_word(on_bus);
				points_taken++;
			end
			// the bus may change only when nothing is offered or the offer was just taken
			if (!point_bus.valid || point_bus.ready) begin
				if (pending_points.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					on_bus = pending_points.pop_front();
					point_bus.valid          <= 1'b1;
					point_bus.layer_value    <= on_bus.layer_value;
					point_bus.back_value     <= on_bus.back_value;
					point_bus.velocity       <= on_bus.velocity;
					point_bus.coef_p         <= on_bus.coef_p;
					point_bus.coef_q         <= on_bus.coef_q;
					point_bus.coef_f         <= on_bus.coef_f;
					point_bus.boundary_value <= on_bus.boundary_value;
					point_bus.is_first       <= on_bus.is_first;
					point_bus.is_last        <= on_bus.is_last;
				end else begin
					point_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result word with the oldest one owed, and stall at random.
	always @(posedge clk) begin
		layer_word_t want;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				results_taken++;
				if (result_bus.saturated)
					clipped_seen++;
				if (result_bus.last_of_layer)
					layers_closed++;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got value %0d index %0d",
						$time, result_bus.new_value, result_bus.point_index);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("new_value", longint'(want.new_value),
						longint'(result_bus.new_value));
					check_field("point_index", longint'(want.point_index),
						longint'(result_bus.point_index));
					check_field("saturated", longint'(want.saturated),
						longint'(result_bus.saturated));
					check_field("last_of_layer", longint'(want.last_of_layer),
						longint'(result_bus.last_of_layer));
				end
			end
			result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run if neither side moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((point_bus.valid && point_bus.ready) || (result_bus.valid && result_bus.ready)) begin
				quiet <= 0;
			end else if (quiet >= WATCHDOG) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_q();
		case ($urandom_range(9))
			0:       return DATA_MAX;
			1:       return DATA_MIN;
			2, 3:    return $urandom;
			// mostly values within +-16.0 so the stencil sum stays in range
			default: return $signed($urandom_range(2097152)) - 1048576;
		endcase
	endfunction

	function automatic grid_word_t rand_word();
		grid_word_t w;
		w.layer_value    = pick_q();
		w.back_value     = pick_q();
		w.velocity       = pick_q();
		w.coef_p         = pick_q();
		w.coef_q         = pick_q();
		w.coef_f         = pick_q();
		w.boundary_value = pick_q();
		w.is_first       = 1'b0;
		w.is_last        = 1'b0;
		return w;
	endfunction

	task automatic push_word(grid_word_t w);
		pending_points.push_back(w);
		points_pushed++;
	endtask

	// Queue one layer of n points; an open layer never sets the last marker.
	task automatic queue_layer(int unsigned n, bit open_end);
		grid_word_t w;
		for (int unsigned i = 0; i < n; i++) begin
			w = rand_word();
			w.is_first = (i == 0);
			w.is_last  = !open_end && (i == n - 1);
			// scramble the markers now and then to break the layer
			if (!open_end && $urandom_range(15) == 0) begin
				w.is_first = 1'($urandom_range(1));
				w.is_last  = 1'($urandom_range(1));
			end
			push_word(w);
		end
	endtask

	// Hold until every queued word is taken and every owed result has come, then let it settle.
	task automatic wait_drained();
		while (points_taken != points_pushed || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t which, logic [COEF_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= val;
		case (which)
			REG_FIRST_STEP_MODE: mode_first = val[0];
			REG_STEP_TIME:       ht         = acc_t'(val);
			REG_STEP_TIME_SQ:    ht2        = acc_t'(val);
			REG_INV_DX2:         inv_dx2    = acc_t'(val);
			REG_INV_2DX:         inv_2dx    = acc_t'(val);
			default: ;
		endcase
	endtask

	// Write the whole register file, only once the block has gone idle.
	task automatic apply_settings(bit mode, logic [COEF_W-1:0] st, logic [COEF_W-1:0] st2,
			logic [COEF_W-1:0] dx2, logic [COEF_W-1:0] dx);
		wait_drained();
		write_reg(REG_FIRST_STEP_MODE, COEF_W'(mode));
		write_reg(REG_STEP_TIME, st);
		write_reg(REG_STEP_TIME_SQ, st2);
		write_reg(REG_INV_DX2, dx2);
		write_reg(REG_INV_2DX, dx);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		grid_word_t  w;
		int unsigned target;
		bit          paused;

		// Drive every input to a known value before the first edge.
		cfg_we                   = 1'b0;
		cfg_index                = REG_FIRST_STEP_MODE;
		cfg_data                 = '0;
		point_bus.valid          = 1'b0;
		point_bus.layer_value    = '0;
		point_bus.back_value     = '0;
		point_bus.velocity       = '0;
		point_bus.coef_p         = '0;
		point_bus.coef_q         = '0;
		point_bus.coef_f         = '0;
		point_bus.boundary_value = '0;
		point_bus.is_first       = 1'b0;
		point_bus.is_last        = 1'b0;
		result_bus.ready         = 1'b0;

		// Predictor starts from the reset register values and a cleared window.
		mode_first = 1'b0;
		ht         = '0;
		ht2        = '0;
		inv_dx2    = acc_t'(INV_DX2_RESET);
		inv_2dx    = acc_t'(INV_2DX_RESET);
		win_left   = '0;
		win_centre = '0;
		held_back  = '0;
		held_vel   = '0;
		held_p     = '0;
		held_q     = '0;
		held_f     = '0;
		grid_pos   = 0;
		steady     = 1'b0;
		paused     = 1'b0;
		settings_used = 1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: zero time step, so interior words reduce to 2c - b.
		// No marker on the first word: the cleared counter makes it point zero.
		w = rand_word();
		push_word(w);
		w = rand_word();
		w.layer_value = DATA_MAX;
		w.back_value  = DATA_MIN;
		push_word(w);
		w = rand_word();
		w.layer_value = DATA_MIN;
		w.back_value  = DATA_MAX;
		push_word(w);
		w = rand_word();
		w.layer_value = '0;
		push_word(w);
		// close the layer: interior word plus right boundary
		w = rand_word();
		w.is_last        = 1'b1;
		w.boundary_value = DATA_MIN;
		push_word(w);
		// no marker right after a layer ended: point zero again
		w = rand_word();
		w.boundary_value = DATA_MAX;
		push_word(w);
		// last at index one: right boundary only
		w = rand_word();
		w.is_last = 1'b1;
		push_word(w);
		// first and last at once: one boundary word that closes the layer
		w = rand_word();
		w.is_first = 1'b1;
		w.is_last  = 1'b1;
		push_word(w);

		// Directed, normal update with field extremes and a restart mid-layer.
		apply_settings(1'b0, 31'd65536, 31'd16384, 31'd65536, 31'd32768);
		w = rand_word();
		w.is_first = 1'b1;
		push_word(w);
		w = '{DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, 1'b0, 1'b0};
		push_word(w);
		w = '{DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, 1'b0, 1'b0};
		push_word(w);
		w = '{DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, 1'b0, 1'b0};
		push_word(w);
		w = '0;
		push_word(w);
		w = rand_word();
		w.is_first = 1'b1;
		push_word(w);
		push_word(rand_word());
		w = rand_word();
		w.is_last = 1'b1;
		push_word(w);

		// Directed, first-step update with every register at its top value.
		apply_settings(1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		w = rand_word();
		w.is_first = 1'b1;
		push_word(w);
		w = '{DATA_MAX, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, 1'b0, 1'b0};
		push_word(w);
		w = '{DATA_MIN, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, 1'b0, 1'b0};
		push_word(w);
		push_word(rand_word());
		w = rand_word();
		w.is_last = 1'b1;
		push_word(w);

		// Full-length layer with no last marker: the point at the size limit closes it,
		// and the word after it starts a new layer unmarked.
		apply_settings(1'b0, COEF_W'($urandom_range(65536)), COEF_W'($urandom_range(32768)),
			COEF_W'($urandom_range(1 << 20)), COEF_W'($urandom_range(1 << 18)));
		queue_layer(GRID_MAX + 2, 1'b1);

		// Random phases: short layers under a spread of register settings.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: apply_settings(1'b0, COEF_W'($urandom_range(65536)),
					COEF_W'($urandom_range(32768)), COEF_W'($urandom_range(1 << 20)),
					COEF_W'($urandom_range(1 << 18)));
				1: apply_settings(1'($urandom_range(1)), COEF_W'($urandom_range(COEF_MAX)),
					COEF_W'($urandom_range(COEF_MAX)), COEF_W'($urandom_range(COEF_MAX)),
					COEF_W'($urandom_range(COEF_MAX)));
				2: apply_settings(1'($urandom_range(1)), '0, '0, '0, '0);
				3: apply_settings(ph % 2 == 1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
				default: apply_settings(1'b1, COEF_W'($urandom_range(65536)),
					COEF_W'($urandom_range(32768)), COEF_W'($urandom_range(1 << 20)),
					COEF_W'($urandom_range(1 << 18)));
			endcase
			// two phases run with no idling on either side
			steady = (ph == 2 || ph == 7);
			target = points_pushed + 50;
			while (points_pushed < target) begin
				queue_layer($urandom_range(1, 16), 1'b0);
				// hold the sender once mid-phase until every owed word has come back
				if (ph == 1 && !paused && points_pushed + 25 >= target) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		$display("Run covered %0d grid words, %0d result words, %0d closed layers, %0d clipped.",
			points_taken, results_taken, layers_closed, clipped_seen);
		$display("Both update formulas over %0d register settings, incl. a full-length layer.",
			settings_used);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
design/wst_pkg.sv
design/wst_if.sv
design/wst_mulq.sv
design/wst_front.sv
design/wst_queue.sv
design/wst_back.sv
design/wave_equation_stencil_step.sv
tb/wave_equation_stencil_step_tb.sv
